/* rtl/core/tlv8p_pkg.sv */
// Shared types, result codes and helpers for the TLV8 reassembling parser.
// No dependencies; imported by every module of the block.
package tlv8p_pkg;

    localparam int LENGTH_BITS_DEF = 16;  // default merged length counter width
    localparam int MAX_RES         = 3;   // results one byte can cause
    localparam int OUT_W           = 16;  // width of offset and length fields
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 56;  // 49 payload bits padded to bytes

    // result kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       item_type;
        logic [7:0]       value_byte;
        logic [OUT_W-1:0] byte_offset;
        logic [OUT_W-1:0] item_length;
        logic             length_saturated;
        logic             last_of_run;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]             cnt;
        result_t [MAX_RES-1:0]  res;
    } bundle_t;

    function automatic result_t mk_res(input logic [1:0] kind, input logic [7:0] typ,
                                       input logic [7:0] val, input logic [OUT_W-1:0] off,
                                       input logic [OUT_W-1:0] len, input logic sat);
        result_t r;
        r.kind             = kind;
        r.item_type        = typ;
        r.value_byte       = val;
        r.byte_offset      = off;
        r.item_length      = len;
        r.length_saturated = sat;
        r.last_of_run      = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/core/tlv8p_core.sv */
// Parse state registers and per-byte next-state / result logic.
// Depends on tlv8p_pkg.
module tlv8p_core import tlv8p_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,        // commit the byte below
    input  logic [7:0] byte_in,
    input  logic       eob_in,
    output bundle_t    bundle       // results of byte_in against current state
);

    localparam int LEN_W = (LENGTH_BITS < OUT_W) ? LENGTH_BITS : OUT_W;

    localparam logic [1:0] PH_TYPE  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    logic [1:0]       phase_reg,      phase_next;
    logic [7:0]       cur_type_reg,   cur_type_next;
    logic [7:0]       chunk_rem_reg,  chunk_rem_next;
    logic             chunk_full_reg, chunk_full_next;
    logic             item_open_reg,  item_open_next;
    logic [LEN_W-1:0] merged_len_reg, merged_len_next;
    logic             sat_reg,        sat_next;

    always_comb begin
        result_t [MAX_RES-1:0] res;
        logic [1:0]  n;
        logic        close;
        logic        go_reset;
        logic [7:0]  rem_dec;
        res             = '0;
        n               = 2'd0;
        close           = 1'b0;
        go_reset        = 1'b0;
        rem_dec         = chunk_rem_reg - 8'd1;
        phase_next      = phase_reg;
        cur_type_next   = cur_type_reg;
        chunk_rem_next  = chunk_rem_reg;
        chunk_full_next = chunk_full_reg;
        item_open_next  = item_open_reg;
        merged_len_next = merged_len_reg;
        sat_next        = sat_reg;

        case (phase_reg)
            PH_TYPE: begin
                // a record of another type closes the open item
                close = item_open_reg && (byte_in != cur_type_reg);
                if (close) begin
                    res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                    OUT_W'(merged_len_reg), sat_reg);
                    n = n + 2'd1;
                end
                if (eob_in) begin
                    if (item_open_reg && !close) begin
                        res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                        OUT_W'(merged_len_reg), sat_reg);
                        n = n + 2'd1;
                    end
                    res[n] = mk_res(KIND_ERR, byte_in, 8'd0, '0, '0, 1'b0);
                    n = n + 2'd1;
                    go_reset = 1'b1;
                end else begin
                    if (!item_open_reg || close) begin
                        merged_len_next = '0;
                        sat_next        = 1'b0;
                    end
                    item_open_next = item_open_reg && !close;
                    cur_type_next  = byte_in;
                    phase_next     = PH_LEN;
                end
            end
            PH_LEN: begin
                if (byte_in == 8'd0) begin
                    // empty chunk: its own zero-length item
                    if (item_open_reg) begin
                        res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                        OUT_W'(merged_len_reg), sat_reg);
                        n = n + 2'd1;
                    end
                    res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0, '0, 1'b0);
                    n = n + 2'd1;
                    item_open_next  = 1'b0;
                    merged_len_next = '0;
                    sat_next        = 1'b0;
                    phase_next      = PH_TYPE;
                end else if (eob_in) begin
                    if (item_open_reg) begin
                        res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                        OUT_W'(merged_len_reg), sat_reg);
                        n = n + 2'd1;
                    end
                    res[n] = mk_res(KIND_ERR, cur_type_reg, 8'd0, '0, '0, 1'b0);
                    n = n + 2'd1;
                    go_reset = 1'b1;
                end else begin
                    chunk_rem_next  = byte_in;
                    chunk_full_next = (byte_in == 8'hFF);
                    item_open_next  = 1'b1;
                    phase_next      = PH_VALUE;
                end
            end
            PH_VALUE: begin
                // counter holds at its limit and flags
                if (merged_len_reg == {LEN_W{1'b1}}) begin
                    sat_next = 1'b1;
                end else begin
                    merged_len_next = merged_len_reg + LEN_W'(1);
                end
                res[n] = mk_res(KIND_VALUE, cur_type_reg, byte_in,
                                OUT_W'(merged_len_reg), '0, sat_next);
                n = n + 2'd1;
                item_open_next = 1'b1;
                chunk_rem_next = rem_dec;
                if (rem_dec == 8'd0) begin
                    phase_next = PH_TYPE;
                    if (!chunk_full_reg || eob_in) begin
                        res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                        OUT_W'(merged_len_next), sat_next);
                        n = n + 2'd1;
                        item_open_next = 1'b0;
                    end
                end else if (eob_in) begin
                    res[n] = mk_res(KIND_END, cur_type_reg, 8'd0, '0,
                                    OUT_W'(merged_len_next), sat_next);
                    n = n + 2'd1;
                    res[n] = mk_res(KIND_ERR, cur_type_reg, 8'd0, '0, '0, 1'b0);
                    n = n + 2'd1;
                    go_reset = 1'b1;
                end
            end
            default: begin
                go_reset = 1'b1;
            end
        endcase

        if (go_reset) begin
            phase_next      = PH_TYPE;
            cur_type_next   = 8'd0;
            chunk_rem_next  = 8'd0;
            chunk_full_next = 1'b0;
            item_open_next  = 1'b0;
            merged_len_next = '0;
            sat_next        = 1'b0;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last_of_run = 1'b1;
        end
        bundle.cnt = n;
        bundle.res = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TYPE;
            cur_type_reg   <= 8'd0;
            chunk_rem_reg  <= 8'd0;
            chunk_full_reg <= 1'b0;
            item_open_reg  <= 1'b0;
            merged_len_reg <= '0;
            sat_reg        <= 1'b0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            cur_type_reg   <= cur_type_next;
            chunk_rem_reg  <= chunk_rem_next;
            chunk_full_reg <= chunk_full_next;
            item_open_reg  <= item_open_next;
            merged_len_reg <= merged_len_next;
            sat_reg        <= sat_next;
        end
    end

    // inside a chunk's value bytes an item is always open
    a_open_in_value: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_VALUE |-> item_open_reg)
        else $error("value phase without an open item");

endmodule

/* rtl/core/tlv8p_obuf.sv */
// Result buffer: holds the results of one byte and presents one per cycle while out_ready is high.
// Depends on tlv8p_pkg.
module tlv8p_obuf import tlv8p_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,       // take bundle_in (only when free)
    input  bundle_t bundle_in,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_res,
    output logic    free        // a new bundle may load this cycle
);

    result_t [MAX_RES-1:0] res_reg;
    logic [1:0]            rem_reg, rem_next;
    logic [1:0]            ptr_reg, ptr_next;
    logic                  pop;

    assign out_valid = (rem_reg != 2'd0);
    assign out_res   = res_reg[ptr_reg];
    assign pop       = out_valid && out_ready;
    assign free      = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop);

    always_comb begin
        rem_next = rem_reg;
        ptr_next = ptr_reg;
        if (load) begin
            rem_next = bundle_in.cnt;
            ptr_next = 2'd0;
        end else if (pop) begin
            rem_next = rem_reg - 2'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= bundle_in.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
        end
    end

    // loading never drops a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (rem_reg == 2'd0) || ((rem_reg == 2'd1) && pop))
        else $error("result buffer overwritten");

endmodule

/* rtl/core/tlv8_fragment_reassembling_parser.sv */
// Top level of the TLV8 parser with fragment reassembly.
// Depends on tlv8p_pkg, tlv8p_core and tlv8p_obuf.
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: data_byte; tlast: end_of_buffer
//  m_      | out | m_tvalid/m_tready  | tdata: type,value,offset,length,saturated;
//          |     |                    | tuser: kind; tlast: last_of_run
//
// One input word per cycle while every byte causes at most one result and m_tready
// is high; after a byte causing two or three results, the input register holds
// while the result buffer drains one word per cycle.
// A byte's first result passes the input register, then the result buffer.
// Reset (aresetn low, synchronous) empties both and returns the parse state to
// "expect type byte". A stall on m_tready holds the result buffer and, once it
// is full, backs up into s_tready.
module tlv8_fragment_reassembling_parser import tlv8p_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_buffer
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] item_type, [15:8] value_byte,
                                            // [31:16] byte_offset, [47:32] item_length,
                                            // [48] length_saturated, [55:49] zero
    output logic [1:0]           m_tuser,   // [1:0] kind
    output logic                 m_tlast    // last_of_run
);

    localparam int LEN_W = (LENGTH_BITS < OUT_W) ? LENGTH_BITS : OUT_W;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eob_reg;

    logic       s_accept;
    logic       advance;    // byte in the input register is committed this cycle
    bundle_t    bundle;
    logic       obuf_free;
    result_t    out_res;

    // a byte commits when its results fit; bytes without results always commit
    assign advance  = in_valid_reg && ((bundle.cnt == 2'd0) || obuf_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[7:0];
            in_eob_reg  <= s_tlast;
        end
    end

    tlv8p_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .byte_in (in_byte_reg),
        .eob_in  (in_eob_reg),
        .bundle  (bundle)
    );

    tlv8p_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && (bundle.cnt != 2'd0)),
        .bundle_in (bundle),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .free      (obuf_free)
    );

    assign m_tdata = {7'd0, out_res.length_saturated, out_res.item_length,
                      out_res.byte_offset, out_res.value_byte, out_res.item_type};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_of_run;

    // a waiting byte stays put until it commits
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                      && $stable(in_eob_reg))
        else $error("input register changed while waiting");

    // a truncation error always closes the run of its byte
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERR) |-> m_tlast)
        else $error("error result not last of run");

    // a saturated value byte sits at the counter limit
    a_sat_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_VALUE) && m_tdata[48]
            |-> m_tdata[31:16] == OUT_W'({LEN_W{1'b1}}))
        else $error("saturated byte below length limit");

endmodule

/* tb/tb.sv */
// Self-checking bench for tlv8_fragment_reassembling_parser: directed and random TLV8
// byte streams. A built-in parse model predicts every result word. Needs tlv8p_pkg.
`timescale 1ns / 100ps

module tb;
    import tlv8p_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 8;      // slack after the expectation queue empties
    localparam int unsigned LEN_LIMIT    = (LENGTH_BITS_DEF >= 16) ? 32'hFFFF
                                         : (32'd1 << LENGTH_BITS_DEF) - 1;
    localparam logic [7:0]  FULL_CHUNK   = 8'd255;

    typedef enum logic [1:0] {SEEK_TYPE, SEEK_LEN, IN_VALUE} tlv_phase_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [7:0] data_byte
    logic                 s_tlast  = 1'b0;  // end_of_buffer
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [7:0] type, [15:8] value, [31:16] offset,
                                            // [47:32] length, [48] saturated, [55:49] zero
    logic [1:0]           m_tuser;          // [1:0] kind
    logic                 m_tlast;          // last_of_run

    // parse state mirrored by the bench
    tlv_phase_t       tlv_phase;
    logic [7:0]       rec_type;
    logic [7:0]       chunk_left;
    logic             chunk_full;
    logic             item_live;
    logic [OUT_W-1:0] merged_len;
    logic             len_sat;

    result_t     burst_q[$];      // results caused by the byte being parsed
    result_t     expected_q[$];   // result words still owed by the DUT
    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned cycle_count = 0;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;

    tlv8_fragment_reassembling_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- parse model

    function automatic void clear_parser();
        tlv_phase  = SEEK_TYPE;
        rec_type   = '0;
        chunk_left = '0;
        chunk_full = 1'b0;
        item_live  = 1'b0;
        merged_len = '0;
        len_sat    = 1'b0;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] typ,
                                 input logic [7:0] val, input logic [OUT_W-1:0] off,
                                 input logic [OUT_W-1:0] len, input logic sat);
        result_t r;
        r.kind             = kind;
        r.item_type        = typ;
        r.value_byte       = val;
        r.byte_offset      = off;
        r.item_length      = len;
        r.length_saturated = sat;
        r.last_of_run      = 1'b0;
        burst_q.push_back(r);
    endfunction

    function automatic void close_item();
        emit(KIND_END, rec_type, 8'd0, '0, merged_len, len_sat);
        item_live = 1'b0;
    endfunction

    // works out the words one accepted byte causes and queues them
    function automatic void parse_byte(input logic [7:0] b, input logic eob);
        logic [OUT_W-1:0] off;
        burst_q.delete();
        case (tlv_phase)
            SEEK_TYPE: begin
                // a new type closes a reassembled item of another type
                if (item_live && b != rec_type)
                    close_item();
                if (eob) begin
                    if (item_live)
                        close_item();
                    emit(KIND_ERR, b, 8'd0, '0, '0, 1'b0);
                    clear_parser();
                end else begin
                    if (!item_live) begin
                        merged_len = '0;
                        len_sat    = 1'b0;
                    end
                    rec_type  = b;
                    tlv_phase = SEEK_LEN;
                end
            end
            SEEK_LEN: begin
                if (b == 8'd0) begin
                    // empty record: an item of its own, even at end of buffer
                    if (item_live)
                        close_item();
                    emit(KIND_END, rec_type, 8'd0, '0, '0, 1'b0);
                    item_live  = 1'b0;
                    merged_len = '0;
                    len_sat    = 1'b0;
                    tlv_phase  = SEEK_TYPE;
                end else if (eob) begin
                    if (item_live)
                        close_item();
                    emit(KIND_ERR, rec_type, 8'd0, '0, '0, 1'b0);
                    clear_parser();
                end else begin
                    chunk_left = b;
                    chunk_full = (b == FULL_CHUNK);
                    item_live  = 1'b1;
                    tlv_phase  = IN_VALUE;
                end
            end
            default: begin
                off = merged_len;
                if (merged_len >= LEN_LIMIT) begin
                    // counter pinned at its limit
                    merged_len = OUT_W'(LEN_LIMIT);
                    off        = OUT_W'(LEN_LIMIT);
                    len_sat    = 1'b1;
                end else begin
                    merged_len = merged_len + 1'b1;
                end
                emit(KIND_VALUE, rec_type, b, off, '0, len_sat);
                item_live  = 1'b1;
                chunk_left = chunk_left - 1'b1;
                if (chunk_left == 8'd0) begin
                    tlv_phase = SEEK_TYPE;
                    if (!chunk_full || eob)
                        close_item();
                end else if (eob) begin
                    close_item();
                    emit(KIND_ERR, rec_type, 8'd0, '0, '0, 1'b0);
                    clear_parser();
                end
            end
        endcase
        if (burst_q.size() > 0)
            burst_q[burst_q.size() - 1].last_of_run = 1'b1;
        foreach (burst_q[i])
            expected_q.push_back(burst_q[i]);
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // each result word is compared with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual kind %0h tdata %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = expected_q.pop_front();
                check_field("kind",             32'(want.kind),      32'(m_tuser));
                check_field("item_type",        32'(want.item_type), 32'(m_tdata[7:0]));
                check_field("value_byte",       32'(want.value_byte), 32'(m_tdata[15:8]));
                check_field("byte_offset",      32'(want.byte_offset), 32'(m_tdata[31:16]));
                check_field("item_length",      32'(want.item_length), 32'(m_tdata[47:32]));
                check_field("length_saturated", 32'(want.length_saturated),
                            32'(m_tdata[48]));
                check_field("tdata padding",    0,                   32'(m_tdata[55:49]));
                check_field("last_of_run",      32'(want.last_of_run), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- input side

    // offers one word, predicts on acceptance, then maybe idles the sender
    task automatic push_byte(input logic [7:0] b, input logic eob);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, eob);
        bytes_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge aclk);
        end
    endtask

    // one record with random value bytes; eob rides on its final byte
    task automatic send_chunk(input logic [7:0] typ, input int len, input logic eob);
        push_byte(typ, 1'b0);
        push_byte(len[7:0], eob && len == 0);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(255)), eob && i == len - 1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_field_extremes();
        push_byte(8'h00, 1'b0);   // type 0, one value byte of 0
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);   // type FF, end of buffer on last value byte
        push_byte(8'h03, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hA5, 1'b1);
    endtask

    task automatic test_empty_records();
        send_chunk(8'h07, 0, 1'b0);
        send_chunk(8'h07, 0, 1'b1);   // empty record as last of buffer
        send_chunk(8'h09, 1, 1'b0);
        send_chunk(8'h09, 0, 1'b0);   // short chunk already closed the item
        send_chunk(8'h09, 2, 1'b1);
    endtask

    task automatic test_truncation();
        push_byte(8'h81, 1'b1);       // buffer ends on a type byte
        push_byte(8'h12, 1'b0);
        push_byte(8'h05, 1'b1);       // ... on a length byte
        push_byte(8'h13, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);       // ... inside the value: value, end, error
    endtask

    // mostly well-formed buffers of short random records, sometimes cut short, some noise
    task automatic send_random_buffer();
        logic [7:0] buf_q[$];
        logic [7:0] typ;
        int         len;
        int         pick;
        int         cut;
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            return;
        end
        typ = 8'($urandom_range(255));
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(2) == 0)
                typ = 8'($urandom_range(255));   // otherwise keep type
            pick = $urandom_range(15);
            if (pick == 0)
                len = 0;
            else
                len = $urandom_range(1, 6);
            buf_q.push_back(typ);
            buf_q.push_back(len[7:0]);
            repeat (len)
                buf_q.push_back(8'($urandom_range(255)));
        end
        cut = ($urandom_range(3) == 0) ? $urandom_range(1, buf_q.size()) : buf_q.size();
        for (int i = 0; i < cut; i++)
            push_byte(buf_q[i], i == cut - 1);
    endtask

    task automatic test_random_stream(input int src_pct, input int sink_pct,
                                      input int unsigned n_bytes);
        int unsigned start;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_buffer();
    endtask

    initial begin
        clear_parser();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_empty_records();
        test_truncation();

        test_random_stream(0, 0, 30);
        test_random_stream(64, 0, 30);
        test_random_stream(0, 64, 30);
        test_random_stream(26, 26, 30);

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tlv8p_pkg.sv
rtl/core/tlv8p_core.sv
rtl/core/tlv8p_obuf.sv
rtl/core/tlv8_fragment_reassembling_parser.sv
tb/tb.sv
